[src/mm3_pkg.sv]
`default_nettype none
package mm3_pkg;

    // Body scramble and mixing constants
    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;

    // fmix32 multipliers
    localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

    // Bytes in a full word
    localparam logic [2:0] FULL_BYTES = 3'd4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One scrambled word on its way to the back end
    typedef struct packed {
        logic [31:0] k;      // scrambled, masked data word
        logic [2:0]  count;  // valid bytes, 0..4
        logic        last;   // closes the message
    } mm3_entry_t;

    // Push side of the queue, driven by the front end
    typedef struct packed {
        logic       valid;
        mm3_entry_t entry;
    } mm3_push_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

endpackage
`default_nettype wire

[src/mm3_front.sv]
`default_nettype none
module mm3_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // data_word[31:0], byte_count[34:32], zero pad
    input  wire logic              s_tlast,
    output mm3_pkg::mm3_push_t     push,
    input  wire logic              push_ready
);
    import mm3_pkg::*;

    logic [31:0] word_in;
    logic [2:0]  count_in;
    logic [2:0]  count_sat;
    logic [31:0] mask;
    logic        load1;
    logic        adv1;
    logic        push_go;

    logic        v1_reg, v1_next;
    logic [31:0] p1_reg;
    logic [2:0]  cnt1_reg;
    logic        last1_reg;

    logic        v2_reg, v2_next;
    logic [31:0] k2_reg;
    logic [2:0]  cnt2_reg;
    logic        last2_reg;

    assign word_in  = s_tdata[31:0];
    assign count_in = s_tdata[34:32];

    // Saturate count and mask off bytes above it
    always_comb begin
        count_sat = (count_in > FULL_BYTES) ? FULL_BYTES : count_in;
        case (count_sat)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    // Stage handshakes
    assign push_go  = v2_reg && push_ready;
    assign adv1     = v1_reg && (!v2_reg || push_go);
    assign s_tready = !v1_reg || adv1;
    assign load1    = s_tvalid && s_tready;

    assign v1_next = load1 ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
    assign v2_next = adv1 ? 1'b1 : (push_go ? 1'b0 : v2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Stage 1: k * C1
    always_ff @(posedge aclk) begin
        if (load1) begin
            p1_reg    <= (word_in & mask) * MIX_C1;
            cnt1_reg  <= count_sat;
            last1_reg <= s_tlast;
        end
    end

    // Stage 2: rotl 15, * C2
    always_ff @(posedge aclk) begin
        if (adv1) begin
            k2_reg    <= rotl15(p1_reg) * MIX_C2;
            cnt2_reg  <= cnt1_reg;
            last2_reg <= last1_reg;
        end
    end

    assign push.valid       = v2_reg;
    assign push.entry.k     = k2_reg;
    assign push.entry.count = cnt2_reg;
    assign push.entry.last  = last2_reg;

endmodule
`default_nettype wire

[src/mm3_queue.sv]
`default_nettype none
module mm3_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mm3_pkg::mm3_push_t push,
    output logic                    push_ready,
    output logic                    pop_valid,
    output mm3_pkg::mm3_entry_t     pop_entry,
    input  wire logic               pop_ready
);
    import mm3_pkg::*;

    mm3_entry_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                     do_push;
    logic                     do_pop;

    assign push_ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule
`default_nettype wire

[src/mm3_back.sv]
`default_nettype none
module mm3_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic                pop_valid,
    input  wire mm3_pkg::mm3_entry_t pop_entry,
    output logic                     pop_ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata    // hash[31:0]
);
    import mm3_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] total_reg, total_next;
    logic        open_reg, open_next;

    logic [31:0] h_base;
    logic [31:0] total_base;
    logic [31:0] h_mix;
    logic [31:0] h_rot;
    logic [31:0] fin_in;
    logic        pop;

    logic        f0_v_reg, f1_v_reg, f2_v_reg, out_v_reg;
    logic [31:0] f0_reg, f1_reg, f2_reg, out_reg;
    logic        out_free, f2_go, f1_go, f0_go, f0_free;

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    // Finalization pipeline handshakes
    assign out_free  = !out_v_reg || m_tready;
    assign f2_go     = f2_v_reg && out_free;
    assign f1_go     = f1_v_reg && (!f2_v_reg || f2_go);
    assign f0_go     = f0_v_reg && (!f1_v_reg || f1_go);
    assign f0_free   = !f0_v_reg || f0_go;
    assign pop_ready = !pop_entry.last || f0_free;
    assign pop       = pop_valid && pop_ready;

    // Running hash update, one word per cycle; a last word waits for a free first fmix32 stage
    always_comb begin
        h_base     = open_reg ? h_reg : seed_reg;
        total_base = open_reg ? total_reg : 32'd0;
        h_mix      = h_base ^ pop_entry.k;
        h_rot      = rotl13(h_mix);
        h_next     = h_reg;
        total_next = total_reg;
        open_next  = open_reg;
        if (pop) begin
            if (pop_entry.count == FULL_BYTES) begin
                h_next = (h_rot << 2) + h_rot + MIX_ADD;
            end else if (pop_entry.count != 3'd0) begin
                h_next = h_mix;
            end else begin
                h_next = h_base;
            end
            total_next = total_base + {29'd0, pop_entry.count};
            open_next  = !pop_entry.last;
        end
        fin_in = h_next ^ total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg     <= '0;
            total_reg <= '0;
            open_reg  <= 1'b0;
        end else begin
            h_reg     <= h_next;
            total_reg <= total_next;
            open_reg  <= open_next;
        end
    end

    // Valid bits of fmix32 stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_v_reg  <= 1'b0;
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (pop && pop_entry.last) begin
                f0_v_reg <= 1'b1;
            end else if (f0_go) begin
                f0_v_reg <= 1'b0;
            end
            if (f0_go) begin
                f1_v_reg <= 1'b1;
            end else if (f1_go) begin
                f1_v_reg <= 1'b0;
            end
            if (f1_go) begin
                f2_v_reg <= 1'b1;
            end else if (f2_go) begin
                f2_v_reg <= 1'b0;
            end
            if (f2_go) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // fmix32 data path: xorshift, multiply, xorshift, multiply, xorshift
    always_ff @(posedge aclk) begin
        if (pop && pop_entry.last) begin
            f0_reg <= fin_in ^ (fin_in >> 16);
        end
        if (f0_go) begin
            f1_reg <= f0_reg * FIN_M1;
        end
        if (f1_go) begin
            f2_reg <= (f1_reg ^ (f1_reg >> 13)) * FIN_M2;
        end
        if (f2_go) begin
            out_reg <= f2_reg ^ (f2_reg >> 16);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && pop_entry.last |=> !open_reg)
        else $error("message still open after last word");

    a_body_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !pop_entry.last |=> open_reg)
        else $error("message not open after body word");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_entry.count <= FULL_BYTES)
        else $error("byte count above four reached back end");

    a_last_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && pop_entry.last |=> f0_v_reg)
        else $error("last word did not enter finalization");
`endif

endmodule
`default_nettype wire

[src/murmur3_32_stream_hash_unit.sv]
`default_nettype none
// MurmurHash3 x86_32 over a byte stream of little-endian 32-bit words.
// Input words arrive on s_tvalid/s_tready with s_tdata holding the data word
// in bits 31:0 and its valid byte count (0..4, above 4 counts as 4) in bits
// 34:32; s_tlast marks the final word of a message. Every word but the last
// should carry 4 bytes; a short word takes the tail mixing.
// Each finished message gives one word on m_tvalid/m_tready: the hash.
// The seed is written through cfg_wr_en/cfg_wr_data; the user must write it only while the
// unit is idle, which the unit does not enforce. It is loaded at the first word of each message.
// Throughput: one word per cycle while m_tready keeps the pipeline moving. The front
// end scrambles each word in a two-stage multiply pipeline, a four-entry queue decouples
// it from the back end, which folds one word per cycle into the running hash but holds a
// last word until the first fmix32 stage is free. An accepted last word passes the 2
// scramble stages, queue, hash update, 2 fmix32 multiply stages and output, then m_tvalid rises.
// When m_tready is low the result holds and the pipeline backs up; the queue
// keeps accepting words until it and the scramble stages are full.
// Reset clears the seed, the running hash, the byte total and all valid bits.
module murmur3_32_stream_hash_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // seed[31:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // data_word[31:0], byte_count[34:32], zero pad
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata        // hash[31:0]
);
    import mm3_pkg::*;

    mm3_push_t  push;
    logic       push_ready;
    logic       pop_valid;
    mm3_entry_t pop_entry;
    logic       pop_ready;

    mm3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_ready (push_ready)
    );

    mm3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    mm3_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop_valid   (pop_valid),
        .pop_entry   (pop_entry),
        .pop_ready   (pop_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

[test/mm3_hash_checker.sv]
// Watches both stream channels of the hash unit, folds every accepted input
// word into its own copy of the running hash and compares each emitted hash
// against the oldest one still owed.
module mm3_hash_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // seed[31:0]
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,       // data_word[31:0], byte_count[34:32], zero pad
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,       // hash[31:0]
    output int               mismatch_count,
    output int               hashes_due_count
);

    // MurmurHash3 x86_32 constants
    localparam logic [31:0] SCR_MUL1  = 32'hcc9e2d51;
    localparam logic [31:0] SCR_MUL2  = 32'h1b873593;
    localparam logic [31:0] ROUND_ADD = 32'he6546b64;
    localparam logic [31:0] FMIX_MUL1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_MUL2 = 32'hc2b2ae35;
    localparam int          SHOW_MAX  = 10;

    logic [31:0] seed_value;
    logic [31:0] acc_hash;
    logic [31:0] byte_sum;
    logic        in_message;
    logic [31:0] hashes_due[$];
    logic [31:0] owed_hash;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_k(input logic [31:0] k);
        logic [31:0] t;
        t = k * SCR_MUL1;
        t = rol32(t, 15);
        t = t * SCR_MUL2;
        return t;
    endfunction

    function automatic logic [31:0] fmix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FMIX_MUL1;
        t = t ^ (t >> 13);
        t = t * FMIX_MUL2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // One accepted word: body round for 4 bytes, tail scramble for 1..3
    function automatic void fold_word(input logic [31:0] word, input logic [2:0] raw_count,
                                      input logic is_last);
        logic [2:0]  nbytes;
        logic [31:0] h;
        logic [31:0] keep;
        nbytes = (raw_count > 3'd4) ? 3'd4 : raw_count;
        if (!in_message) begin
            acc_hash   = seed_value;
            byte_sum   = '0;
            in_message = 1'b1;
        end
        h = acc_hash;
        if (nbytes == 3'd4) begin
            h = h ^ scramble_k(word);
            h = rol32(h, 13);
            h = h * 32'd5 + ROUND_ADD;
        end else if (nbytes != 3'd0) begin
            keep = (32'h1 << (8 * nbytes)) - 32'h1;
            h = h ^ scramble_k(word & keep);
        end
        acc_hash = h;
        byte_sum = byte_sum + {29'd0, nbytes};
        if (is_last) begin
            hashes_due.push_back(fmix(acc_hash ^ byte_sum));
            in_message = 1'b0;
        end
    endfunction

    // Results are checked before the same edge's input word is folded in
    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_value = '0;
            acc_hash   = '0;
            byte_sum   = '0;
            in_message = 1'b0;
            hashes_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (hashes_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("%0t: unexpected hash %08h, none owed", $realtime, m_tdata);
                end else begin
                    owed_hash = hashes_due.pop_front();
                    if (m_tdata !== owed_hash) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_MAX)
                            $display("%0t: hash mismatch: expected %08h, got %08h",
                                     $realtime, owed_hash, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                fold_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
            if (cfg_wr_en)
                seed_value = cfg_wr_data;
        end
        hashes_due_count = hashes_due.size();
    end

endmodule

[test/testbench.sv]
module testbench;

    localparam int QUIET_LIMIT   = 4000;  // cycles without any word moving
    localparam int SETTLE_CYCLES = 12;    // output latency plus margin
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 340;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;  // data_word[31:0], byte_count[34:32], zero pad
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;           // hash[31:0]

    int mismatch_count;
    int hashes_due_count;
    int quiet_cycles;
    int words_sent;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_req;

    murmur3_32_stream_hash_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    mm3_hash_checker u_hash_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .hashes_due_count (hashes_due_count)
    );

    always #4 aclk = ~aclk;

    // Watchdog: count cycles in which neither channel moves a word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold on request
    initial begin : ready_driver
        int n;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one word, with an optional idle burst ahead of it
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic closing);
        int gap;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, nbytes, data};
        s_tlast  <= closing;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Stop offering, wait for every owed hash, then let the pipeline drain
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (hashes_due_count == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed messages; noisy ones get odd counts anywhere
    task automatic send_message(input int n_words, input bit noisy);
        logic [2:0] nbytes;
        bit         closing;
        for (int i = 0; i < n_words; i++) begin
            closing = (i == n_words - 1);
            nbytes  = closing ? 3'($urandom_range(0, 4)) : 3'd4;
            if (noisy && $urandom_range(0, 3) == 0)
                nbytes = 3'($urandom_range(0, 7));
            send_word($urandom, nbytes, closing);
        end
    endtask

    initial begin
        int          r;
        int          n_words;
        int          phase_start;
        bit          hold_done;
        logic [31:0] phase_seed;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty message under the reset seed
        send_word(32'hdeadbeef, 3'd0, 1'b1);
        settle();
        write_seed(32'hffffffff);
        // All-ones then all-zero full words
        send_word(32'hffffffff, 3'd4, 1'b0);
        send_word(32'h00000000, 3'd4, 1'b1);
        // Tail words with junk above the valid bytes
        send_word(32'hffffff5a, 3'd1, 1'b1);
        send_word(32'hffff1234, 3'd2, 1'b1);
        send_word(32'hffabcdef, 3'd3, 1'b1);
        // Counts above four saturate
        send_word(32'h01234567, 3'd5, 1'b1);
        send_word(32'h89abcdef, 3'd6, 1'b1);
        send_word(32'h5a5aa5a5, 3'd7, 1'b1);
        // Short and empty words inside a message
        send_word(32'hcafe0042, 3'd2, 1'b0);
        send_word(32'h0badf00d, 3'd0, 1'b0);
        send_word(32'h76543210, 3'd4, 1'b0);
        send_word(32'h000000ff, 3'd1, 1'b1);
        // Four full words
        send_word(32'h11111111, 3'd4, 1'b0);
        send_word(32'h22222222, 3'd4, 1'b0);
        send_word(32'h33333333, 3'd4, 1'b0);
        send_word(32'h44444444, 3'd4, 1'b1);
        // New seed mid-message only applies to the next message
        settle();
        write_seed(32'h80000000);
        send_word(32'h80000000, 3'd4, 1'b0);
        settle();
        write_seed(32'h7fffffff);
        send_word(32'h7fffffff, 3'd4, 1'b1);
        send_word(32'h00000001, 3'd1, 1'b1);

        // Random phases, each under its own seed; the last one runs without idling
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0:       phase_seed = 32'hffffffff;
                2:       phase_seed = 32'h00000000;
                default: phase_seed = $urandom;
            endcase
            write_seed(phase_seed);
            tx_idle_on  = (ph < 4);
            rx_idle_on  = (ph < 4);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    n_words = $urandom_range(1, 6);
                else if (r < 95)
                    n_words = $urandom_range(7, 20);
                else
                    n_words = $urandom_range(21, 64);
                send_message(n_words, $urandom_range(0, 4) == 0);

                // Long result-side hold while words keep coming
                if (ph == 1 && !hold_done && words_sent - phase_start > 100) begin
                    hold_done   = 1'b1;
                    rx_hold_req = 1'b1;
                    repeat (40) send_word($urandom, 3'($urandom_range(0, 4)), 1'b1);
                    settle();
                end
                if ($urandom_range(0, 49) == 0)
                    settle();
            end
        end

        settle();
        if (mismatch_count == 0 && hashes_due_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
